// ----- hw/rtl/swcs_pkg.sv -----
// Shared types, widths and codes for the sliding-window congestion sender.
// Used by the channel interfaces, the top level and the port checker.
package swcs_pkg;

    // Sequence and window widths
    localparam int SEQ_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int CWND_W     = 32;
    localparam int THR_W      = 16;
    localparam int RWIN_W     = 16;
    localparam int SWIN_W     = 8;
    localparam int ROOM_W     = 16;
    localparam int ACT_W      = 3;
    localparam int OPC_W      = 2;
    localparam int PSEQ_W     = 15;
    localparam int DUP_W      = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [SWIN_W-1:0] SWIN_RST = SWIN_W'(100);
    localparam logic [RWIN_W-1:0] RWIN_RST = RWIN_W'(16);
    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(128);

    // Duplicate ACK counter: saturation value and the count that fires
    localparam logic [DUP_W-1:0] DUP_MAX  = DUP_W'(7);
    localparam logic [DUP_W-1:0] DUP_FIRE = DUP_W'(4);

    // One packet in 16.16, and the largest threshold
    localparam logic [CWND_W-1:0] CWND_ONE = CWND_W'(1) << FRAC_W;
    localparam logic [THR_W-1:0]  THR_MAX  = {THR_W{1'b1}};

    // Divider for the congestion avoidance step: quotient and remainder
    localparam int QUOT_W = FRAC_W + 1;
    localparam int REM_W  = CWND_W + 1;
    localparam int CNT_W  = $clog2(QUOT_W);

    // Compare widths
    localparam int WIDE_W = (SEQ_W + FRAC_W > CWND_W) ? SEQ_W + FRAC_W : CWND_W;
    localparam int THRC_W = (THR_W + FRAC_W > CWND_W) ? THR_W + FRAC_W : CWND_W;

    typedef enum logic [OPC_W-1:0] {
        OP_SEND  = 2'd0,
        OP_ACK   = 2'd1,
        OP_TIMER = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_SEND    = 3'd1,
        ACT_BLOCKED = 3'd2,
        ACT_PROBE   = 3'd3,
        ACT_RETX    = 3'd4,
        ACT_END     = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWIN = 2'd0,
        CFG_RWIN = 2'd1,
        CFG_THR  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADD,
        ST_CHECK,
        ST_OUT
    } t_state;

    // Low bits of a sequence number as carried on the result word
    function automatic logic [PSEQ_W-1:0] f_pkt_seq(input logic [SEQ_W-1:0] s);
        logic [SEQ_W+PSEQ_W-1:0] w;
        w = (SEQ_W + PSEQ_W)'(s);
        return w[PSEQ_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/swcs_if.sv -----
// Valid/ready channel interfaces for the sliding-window congestion sender.
// Depends on swcs_pkg for the field widths.
interface swcs_in_if
    import swcs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic                     data_ends;
    logic signed [SEQ_W-1:0]  ack_seq;
    logic [ROOM_W-1:0]        ack_room;
    logic                     ack_probe;

    modport source (output valid, opcode, data_ends, ack_seq, ack_room, ack_probe,
                    input ready);
    modport sink   (input valid, opcode, data_ends, ack_seq, ack_room, ack_probe,
                    output ready);
endinterface

interface swcs_out_if
    import swcs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [PSEQ_W-1:0]    packet_seq;
    logic                 window_full;
    logic [CWND_W-1:0]    cwnd_now;
    logic [THR_W-1:0]     threshold_now;
    logic                 last_of_run;

    modport source (output valid, action, packet_seq, window_full, cwnd_now,
                    threshold_now, last_of_run, input ready);
    modport sink   (input valid, action, packet_seq, window_full, cwnd_now,
                    threshold_now, last_of_run, output ready);
endinterface

// ----- hw/rtl/sliding_window_congestion_sender.sv -----
// Send, timer, probe ACK, end ACK and idle answers show a result word the cycle after
// accept; a slow start ACK goes through the check state, a congestion avoidance ACK
// through 17 divide steps of the shared compare/subtract unit, one add and one check.
// Up to two result words per input word. One input word at a time: ready stays low until
// the last result word is taken.
// Reset (synchronous, active low) loads the register reset values and the initial state.
module sliding_window_congestion_sender
    import swcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    swcs_in_if.sink               i_in,
    swcs_out_if.source            o_out
);

    t_state              r_state, n_state;
    logic [SWIN_W-1:0]   r_swin, n_swin;
    logic [RWIN_W-1:0]   r_irwin, n_irwin;
    logic [THR_W-1:0]    r_ithr, n_ithr;
    logic [SEQ_W-1:0]    r_next_seq, n_next_seq;
    logic [SEQ_W-1:0]    r_acked_seq, n_acked_seq;
    logic [DUP_W-1:0]    r_dup, n_dup;
    logic [CWND_W-1:0]   r_cwnd, n_cwnd;
    logic [THR_W-1:0]    r_thr, n_thr;
    logic                r_ss, n_ss;
    logic [RWIN_W-1:0]   r_rwin, n_rwin;
    logic                r_data_done, n_data_done;
    logic                r_finished, n_finished;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [QUOT_W-1:0]   r_quot, n_quot;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    t_action             r_act0, n_act0, r_act1, n_act1;
    logic [SEQ_W-1:0]    r_seq0, n_seq0, r_seq1, n_seq1;
    logic                r_full0, n_full0;
    logic                r_two, n_two;
    logic                r_idx, n_idx;

    // Decoded input and shared terms
    logic                in_acc;
    logic [SEQ_W-1:0]    ack_a;
    logic [SEQ_W-1:0]    seq_gap;
    logic                dist_pos;
    logic [WIDE_W-1:0]   dist_w;
    logic                send_ok;
    logic                send_full;
    logic [CWND_W-1:0]   half_cwnd;
    logic [THR_W-1:0]    cut_thr;
    logic [REM_W-1:0]    rem_sh;
    logic                rem_ge;
    logic [CWND_W:0]     ss_sum;
    logic [CWND_W-1:0]   ss_cwnd;
    logic [CWND_W:0]     ca_sum;
    logic [CWND_W-1:0]   ca_inc;
    logic [THRC_W-1:0]   thr_fix;
    logic [CWND_W-1:0]   cfg_word;

    assign in_acc = i_in.valid && i_in.ready;
    assign ack_a  = SEQ_W'(i_in.ack_seq);

    // Window test on the signed distance from the last ACK to the next sequence
    assign seq_gap   = r_next_seq - r_acked_seq;
    assign dist_pos  = !seq_gap[SEQ_W-1] && (seq_gap != '0);
    assign dist_w    = WIDE_W'(seq_gap);
    assign send_full = dist_pos && (dist_w > WIDE_W'(r_swin));
    assign send_ok   = !r_data_done &&
                       (!dist_pos || ((dist_w <= WIDE_W'(r_rwin)) &&
                                      (dist_w <= WIDE_W'(r_swin)) &&
                                      ((dist_w << FRAC_W) <= WIDE_W'(r_cwnd))));

    // Halve into whole packets, clamped to the threshold range
    assign half_cwnd = r_cwnd >> (FRAC_W + 1);
    assign cut_thr   = (half_cwnd == '0) ? THR_W'(1) :
                       (half_cwnd > CWND_W'(THR_MAX)) ? THR_MAX : THR_W'(half_cwnd);

    // Shared divide step: shift the remainder, compare and subtract
    assign rem_sh = {r_rem[REM_W-2:0], 1'b0};
    assign rem_ge = rem_sh >= REM_W'(r_cwnd);

    // Window growth
    assign ss_sum  = {1'b0, r_cwnd} + {1'b0, CWND_ONE};
    assign ss_cwnd = ss_sum[CWND_W] ? {CWND_W{1'b1}} : ss_sum[CWND_W-1:0];
    assign thr_fix = THRC_W'(r_thr) << FRAC_W;
    assign ca_inc  = (r_cwnd == '0) ? '0 : CWND_W'(r_quot);
    assign ca_sum  = {1'b0, r_cwnd} + {1'b0, ca_inc};
    assign cfg_word = CWND_W'(i_cfg_wdata);

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_swin      <= SWIN_RST;
            r_irwin     <= RWIN_RST;
            r_ithr      <= THR_RST;
            r_next_seq  <= '0;
            r_acked_seq <= '1;
            r_dup       <= DUP_W'(1);
            r_cwnd      <= CWND_ONE;
            r_thr       <= THR_RST;
            r_ss        <= 1'b1;
            r_rwin      <= RWIN_RST;
            r_data_done <= 1'b0;
            r_finished  <= 1'b0;
            r_two       <= 1'b0;
            r_idx       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_swin      <= n_swin;
            r_irwin     <= n_irwin;
            r_ithr      <= n_ithr;
            r_next_seq  <= n_next_seq;
            r_acked_seq <= n_acked_seq;
            r_dup       <= n_dup;
            r_cwnd      <= n_cwnd;
            r_thr       <= n_thr;
            r_ss        <= n_ss;
            r_rwin      <= n_rwin;
            r_data_done <= n_data_done;
            r_finished  <= n_finished;
            r_two       <= n_two;
            r_idx       <= n_idx;
        end
    end

    // Payload registers: divider and result slots
    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quot  <= n_quot;
        r_cnt   <= n_cnt;
        r_act0  <= n_act0;
        r_act1  <= n_act1;
        r_seq0  <= n_seq0;
        r_seq1  <= n_seq1;
        r_full0 <= n_full0;
    end

    // Sequencer: next state, state updates and result slots
    always_comb begin
        n_state     = r_state;
        n_swin      = r_swin;
        n_irwin     = r_irwin;
        n_ithr      = r_ithr;
        n_next_seq  = r_next_seq;
        n_acked_seq = r_acked_seq;
        n_dup       = r_dup;
        n_cwnd      = r_cwnd;
        n_thr       = r_thr;
        n_ss        = r_ss;
        n_rwin      = r_rwin;
        n_data_done = r_data_done;
        n_finished  = r_finished;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_act0      = r_act0;
        n_act1      = r_act1;
        n_seq0      = r_seq0;
        n_seq1      = r_seq1;
        n_full0     = r_full0;
        n_two       = r_two;
        n_idx       = r_idx;

        // Configuration writes: make them only while idle; the block does not check
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SWIN: begin
                    n_swin = SWIN_W'(cfg_word);
                end
                CFG_RWIN: begin
                    n_irwin = RWIN_W'(cfg_word);
                    n_rwin  = RWIN_W'(cfg_word);
                end
                CFG_THR: begin
                    n_ithr = THR_W'(cfg_word);
                    n_thr  = (cfg_word == '0) ? THR_W'(1) : THR_W'(cfg_word);
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_act0  = ACT_NONE;
                    n_seq0  = '0;
                    n_full0 = 1'b0;
                    n_two   = 1'b0;
                    n_idx   = 1'b0;
                    n_state = ST_OUT;
                    if (!r_finished) begin
                        case (t_opcode'(i_in.opcode))
                            OP_SEND: begin
                                if (send_ok) begin
                                    n_act0     = ACT_SEND;
                                    n_seq0     = r_next_seq;
                                    n_next_seq = r_next_seq + SEQ_W'(1);
                                    if (i_in.data_ends) begin
                                        n_data_done = 1'b1;
                                    end
                                end else begin
                                    n_act0  = ACT_BLOCKED;
                                    n_seq0  = r_next_seq;
                                    n_full0 = send_full;
                                end
                            end
                            OP_TIMER: begin
                                // Cut the window and retransmit, probing a closed receiver
                                n_thr  = cut_thr;
                                n_cwnd = CWND_ONE;
                                n_ss   = 1'b1;
                                if (r_rwin == '0) begin
                                    n_act0 = ACT_PROBE;
                                    n_seq0 = r_next_seq;
                                    n_act1 = ACT_RETX;
                                    n_seq1 = r_acked_seq + SEQ_W'(1);
                                    n_two  = 1'b1;
                                end else begin
                                    n_act0 = ACT_RETX;
                                    n_seq0 = r_acked_seq + SEQ_W'(1);
                                end
                            end
                            OP_ACK: begin
                                n_rwin = RWIN_W'(i_in.ack_room);
                                if (!i_in.ack_probe) begin
                                    n_acked_seq = ack_a;
                                    if (ack_a == r_acked_seq) begin
                                        if (r_dup < DUP_MAX) begin
                                            n_dup = r_dup + DUP_W'(1);
                                        end
                                    end else begin
                                        n_dup = DUP_W'(1);
                                    end
                                    if (r_data_done && (ack_a == r_next_seq - SEQ_W'(1))) begin
                                        n_finished = 1'b1;
                                        n_act0     = ACT_END;
                                        n_seq0     = r_next_seq;
                                    end else if (r_ss) begin
                                        n_cwnd = ss_cwnd;
                                        if (THRC_W'(ss_cwnd) > thr_fix) begin
                                            n_ss = 1'b0;
                                        end
                                        n_state = ST_CHECK;
                                    end else begin
                                        // Start 2^(2F) / cwnd; cwnd never drops below one packet
                                        n_rem   = REM_W'(1) << (FRAC_W - 1);
                                        n_quot  = '0;
                                        n_cnt   = CNT_W'(QUOT_W - 1);
                                        n_state = ST_DIV;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle
                n_rem  = rem_ge ? (rem_sh - REM_W'(r_cwnd)) : rem_sh;
                n_quot = {r_quot[QUOT_W-2:0], rem_ge};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_cwnd  = ca_sum[CWND_W] ? {CWND_W{1'b1}} : ca_sum[CWND_W-1:0];
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // No action, or on the third duplicate ACK: cut, retransmit and probe a closed receiver
                n_idx   = 1'b0;
                n_two   = 1'b0;
                n_full0 = 1'b0;
                n_act0  = ACT_NONE;
                n_seq0  = '0;
                n_state = ST_OUT;
                if (r_dup == DUP_FIRE) begin
                    n_thr  = cut_thr;
                    n_cwnd = CWND_ONE;
                    n_ss   = 1'b1;
                    if (r_rwin == '0) begin
                        n_act0 = ACT_PROBE;
                        n_seq0 = r_next_seq;
                        n_act1 = ACT_RETX;
                        n_seq1 = r_acked_seq + SEQ_W'(1);
                        n_two  = 1'b1;
                    end else begin
                        n_act0 = ACT_RETX;
                        n_seq0 = r_acked_seq + SEQ_W'(1);
                    end
                end
            end
            ST_OUT: begin
                // Advance through the result slots
                if (o_out.ready) begin
                    if (r_two && !r_idx) begin
                        n_idx = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Drive the channels
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = (r_state == ST_OUT);
    assign o_out.action        = r_idx ? r_act1 : r_act0;
    assign o_out.packet_seq    = f_pkt_seq(r_idx ? r_seq1 : r_seq0);
    assign o_out.window_full   = r_idx ? 1'b0 : r_full0;
    assign o_out.cwnd_now      = r_cwnd;
    assign o_out.threshold_now = r_thr;
    assign o_out.last_of_run   = !r_two || r_idx;

endmodule

// ----- hw/rtl/swcs_checker.sv -----
// Port-level checks for the sliding-window congestion sender, bound to the top level.
// Depends on swcs_pkg for widths and the one-packet constant.
module swcs_checker
    import swcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [CWND_W-1:0] i_cwnd_now,
    input  logic [THR_W-1:0]  i_threshold_now
);

    // Never take a new word while a result is still on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready))
        else $error("input ready while a result word is pending");

    // Drop ready right after an accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready held after an accepted word");

    // Hold a result word until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped before taken");

    // Threshold never reaches zero
    a_thr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_threshold_now != '0))
        else $error("threshold reported as zero");

    // Congestion window never falls below one packet
    a_cwnd_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cwnd_now >= CWND_ONE))
        else $error("congestion window below one packet");

endmodule

bind sliding_window_congestion_sender swcs_checker u_swcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_cwnd_now      (o_out.cwnd_now),
    .i_threshold_now (o_out.threshold_now)
);
